FILE: hw/rtl/srat_pkg.sv
// Shared types and constants for the section range address translator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package srat_pkg;

  // Table geometry.
  localparam int MAX_SECTIONS = 16;
  localparam int IDX_W        = $clog2(MAX_SECTIONS);
  localparam int CNT_W        = 5;
  localparam int ADDR_W       = 32;
  localparam int HIT_W        = 4;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_V2F  = 2'd1;
  localparam logic [1:0] OP_F2V  = 2'd2;

  // Address returned when no window holds the query address.
  localparam logic [ADDR_W-1:0] MISS_VALUE = '1;

  // Input item.
  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        entry_index;
    logic [ADDR_W-1:0] entry_virtual_start;
    logic [ADDR_W-1:0] entry_raw_start;
    logic [ADDR_W-1:0] entry_raw_size;
    logic [ADDR_W-1:0] query_address;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [ADDR_W-1:0] translated_address;
    logic              found;
    logic [HIT_W-1:0]  hit_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

FILE: hw/rtl/srat_datapath.sv
// Datapath of the section range address translator: section table, count
// register, scan with window compare, and the result register.
// Depends on srat_pkg.
module srat_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  srat_pkg::dp_cmd_t      cmd,
  output srat_pkg::dp_status_t   status,
  input  srat_pkg::in_item_t     in_data,
  input  logic                   cfg_valid,
  input  logic [srat_pkg::CNT_W-1:0] cfg_data,
  output srat_pkg::out_item_t    out_data
);

  localparam int ENTRY_W = 3 * srat_pkg::ADDR_W;
  localparam int AW      = srat_pkg::ADDR_W;

  // Section table: {virtual start, raw start, raw size} per entry.
  logic [ENTRY_W-1:0] table_mem [srat_pkg::MAX_SECTIONS];
  logic [ENTRY_W-1:0] rd_data;

  logic [srat_pkg::CNT_W-1:0] section_count;
  logic [srat_pkg::CNT_W-1:0] lim;
  logic [srat_pkg::CNT_W-1:0] rd_idx;
  logic [srat_pkg::IDX_W-1:0] rd_num;
  logic                       rd_valid;
  logic [1:0]                 q_op;
  logic [AW-1:0]              q_addr;
  logic                       hit;
  logic [srat_pkg::IDX_W-1:0] hit_num;
  logic [AW-1:0]              hit_addr;

  logic          issue;
  logic          slot_ok;
  logic [AW-1:0] e_virt, e_raw, e_size, win_from, win_to;
  logic [AW:0]   win_end;
  logic          match;
  logic [AW-1:0] xlat;

  // Table write for load beats; slots beyond the table are dropped.
  assign slot_ok = (32'(in_data.entry_index) < 32'(srat_pkg::MAX_SECTIONS));

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      table_mem[in_data.entry_index[srat_pkg::IDX_W-1:0]] <=
        {in_data.entry_virtual_start, in_data.entry_raw_start, in_data.entry_raw_size};
    end
  end

  // Registered table read at the scan pointer.
  always_ff @(posedge clk) begin
    rd_data <= table_mem[rd_idx[srat_pkg::IDX_W-1:0]];
  end

  // Count register; user must write it only while idle: not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      section_count <= '0;
    end else if (cfg_valid) begin
      section_count <= cfg_data;
    end
  end

  // A read is issued while entries remain and no hit has been found.
  assign issue = cmd.step && !hit && (rd_idx < lim);

  // Window test on the entry read last cycle; the end is one bit wider.
  assign e_virt   = rd_data[ENTRY_W-1 -: AW];
  assign e_raw    = rd_data[2*AW-1 -: AW];
  assign e_size   = rd_data[AW-1:0];
  assign win_from = (q_op == srat_pkg::OP_V2F) ? e_virt : e_raw;
  assign win_to   = (q_op == srat_pkg::OP_V2F) ? e_raw : e_virt;
  assign win_end  = {1'b0, win_from} + {1'b0, e_size};
  assign match    = (q_addr >= win_from) && ({1'b0, q_addr} < win_end);
  assign xlat     = q_addr - win_from + win_to;

  // Scan control and hit capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      hit      <= 1'b0;
      rd_idx   <= '0;
      lim      <= '0;
    end else if (cmd.start) begin
      rd_valid <= 1'b0;
      hit      <= 1'b0;
      rd_idx   <= '0;
      lim      <= (section_count > srat_pkg::CNT_W'(srat_pkg::MAX_SECTIONS)) ?
                  srat_pkg::CNT_W'(srat_pkg::MAX_SECTIONS) : section_count;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_valid && match && !hit) begin
        hit <= 1'b1;
      end
    end
  end

  // Query operands and the captured hit payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_op   <= in_data.opcode;
      q_addr <= in_data.query_address;
    end
    if (issue) begin
      rd_num <= rd_idx[srat_pkg::IDX_W-1:0];
    end
    if (rd_valid && match && !hit) begin
      hit_num  <= rd_num;
      hit_addr <= xlat;
    end
  end

  assign status.scan_done = hit || ((rd_idx >= lim) && !rd_valid);

  // Result register, loaded when the controller emits a beat.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (hit) begin
        out_data.translated_address <= hit_addr;
        out_data.found              <= 1'b1;
        out_data.hit_index          <= srat_pkg::HIT_W'(hit_num);
      end else begin
        out_data.translated_address <= srat_pkg::MISS_VALUE;
        out_data.found              <= 1'b0;
        out_data.hit_index          <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/srat_ctrl.sv
// Controller of the section range address translator: accepts beats,
// sequences the table scan and hands results to the output register.
// Depends on srat_pkg.
module srat_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output srat_pkg::dp_cmd_t    cmd,
  input  srat_pkg::dp_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state;
  logic   in_fire;
  logic   is_query;
  logic   slot_free;

  assign in_fire   = in_valid && in_ready;
  assign is_query  = (in_opcode == srat_pkg::OP_V2F) || (in_opcode == srat_pkg::OP_F2V);
  assign slot_free = !out_valid || out_ready;

  // Commands to the datapath.
  assign cmd.load  = in_fire && (in_opcode == srat_pkg::OP_LOAD);
  assign cmd.start = in_fire && is_query;
  assign cmd.step  = (state == S_SCAN);
  assign cmd.emit  = (state == S_RESULT) && slot_free;

  // State and the registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // A new result beat replaces one that is taken in the same cycle.
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && is_query) begin
            state    <= S_SCAN;
            in_ready <= 1'b0;
          end
        end
        S_SCAN: begin
          if (status.scan_done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/section_range_address_translator.sv
// Top level of the section range address translator.
// Depends on srat_pkg, srat_ctrl and srat_datapath.
//
// A load beat writes one section entry and the next beat may follow at once. A
// query beat closes the input and searches entries 0 .. section_count-1 (at
// most sixteen) one per cycle through the section table's single read port.
// With no hit, the result beat follows the reads of the searched entries, the
// compare of the last entry, a step in which the controller sees the end of
// the scan and the load of the result register. A hit ends the scan early; a
// search of no entries gives a miss. The input reopens together with the
// result beat, so the next beat may be accepted while the result beat is
// shown. Beats carrying an unused opcode are taken and dropped. The result
// register lets the next beat be accepted while a result still waits; a query
// that finishes while the previous result is still stalled holds until it is
// taken. Write section_count only while no query is in progress.
module section_range_address_translator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  srat_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output srat_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [srat_pkg::CNT_W-1:0] cfg_data
);

  srat_pkg::dp_cmd_t    cmd;
  srat_pkg::dp_status_t status;

  // The count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  srat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  srat_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/srat_checker.sv
// Port-level checks for the section range address translator, bound to
// the top level. Depends on srat_pkg.
module srat_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input srat_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input srat_pkg::out_item_t out_data
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A miss carries all ones and a zero index.
  a_miss_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      out_data.translated_address == srat_pkg::MISS_VALUE && out_data.hit_index == '0)
    else $error("miss result malformed");

  // A load beat leaves the input open for the next beat.
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == srat_pkg::OP_LOAD |=> in_ready)
    else $error("input closed after a load beat");

  // A query beat closes the input while the table is searched.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
      (in_data.opcode == srat_pkg::OP_V2F || in_data.opcode == srat_pkg::OP_F2V)
      |=> !in_ready)
    else $error("input open during a search");

endmodule

bind section_range_address_translator srat_checker u_srat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
